/* hdl/tgca_pkg.sv */
`timescale 1ns / 1ps

package tgca_pkg;

   localparam int MEMBER_W = 3;
   localparam int MAX_W    = 5;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_WAIT   = 2'd1,
      ST_INSIDE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_FINISH
   } state_type;

   localparam logic CMD_ENTER = 1'b0;
   localparam logic CMD_LEAVE = 1'b1;

   typedef struct packed {
      logic en;
      logic leave;
      logic grp;
   } wr_type;

   typedef struct packed {
      logic valid;
      logic grp;
   } cell_grant_type;

endpackage

/* hdl/tgca_cell.sv */
`timescale 1ns / 1ps

module tgca_cell
   import tgca_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  wr_type               wr,
   input  logic [MEMBER_W-1:0]  wr_member,
   input  logic [MAX_W-1:0]     max_inside,
   input  logic                 tok_in_valid,
   input  logic [CW-1:0]        tok_in_cnt_a,
   input  logic [CW-1:0]        tok_in_cnt_b,
   output logic                 tok_out_valid,
   output logic [CW-1:0]        tok_out_cnt_a,
   output logic [CW-1:0]        tok_out_cnt_b,
   output cell_grant_type       grant,
   output logic                 drop
);

   status_type    status_a_ff, status_a_in;
   status_type    status_b_ff, status_b_in;
   logic          tok_valid_ff, tok_valid_in;
   logic          tok_phase_ff, tok_phase_in;
   logic [CW-1:0] tok_cnt_a_ff, tok_cnt_a_in;
   logic [CW-1:0] tok_cnt_b_ff, tok_cnt_b_in;

   logic       hit;
   logic       below_a;
   logic       below_b;
   logic       grant_a;
   logic       grant_b;
   status_type cur;

   always_comb begin
      hit     = wr.en && (32'(wr_member) == IDX);
      cur     = wr.grp ? status_b_ff : status_a_ff;
      drop    = hit && (cur == ST_INSIDE);
      below_a = {{MAX_W{1'b0}}, tok_cnt_a_ff} < {{CW{1'b0}}, max_inside};
      below_b = {{MAX_W{1'b0}}, tok_cnt_b_ff} < {{CW{1'b0}}, max_inside};
      grant_a = tok_valid_ff && !tok_phase_ff && (tok_cnt_b_ff == '0) &&
                (status_a_ff == ST_WAIT) && below_a;
      grant_b = tok_valid_ff && tok_phase_ff && (tok_cnt_a_ff == '0) &&
                (status_b_ff == ST_WAIT) && below_b;
      grant.valid = grant_a || grant_b;
      grant.grp   = tok_phase_ff;

      tok_out_valid = tok_valid_ff && tok_phase_ff;
      tok_out_cnt_a = tok_cnt_a_ff;
      tok_out_cnt_b = tok_cnt_b_ff + CW'(grant_b);

      status_a_in = status_a_ff;
      status_b_in = status_b_ff;
      if (hit) begin
         if (wr.grp) begin
            status_b_in = (wr.leave == CMD_LEAVE) ? ST_IDLE : ST_WAIT;
         end else begin
            status_a_in = (wr.leave == CMD_LEAVE) ? ST_IDLE : ST_WAIT;
         end
      end
      if (step && grant_a) begin
         status_a_in = ST_INSIDE;
      end
      if (step && grant_b) begin
         status_b_in = ST_INSIDE;
      end

      tok_valid_in = tok_valid_ff;
      tok_phase_in = tok_phase_ff;
      tok_cnt_a_in = tok_cnt_a_ff;
      tok_cnt_b_in = tok_cnt_b_ff;
      if (step) begin
         if (tok_valid_ff && !tok_phase_ff) begin
            tok_phase_in = 1'b1;
            tok_cnt_a_in = tok_cnt_a_ff + CW'(grant_a);
         end else begin
            tok_valid_in = tok_in_valid;
            tok_phase_in = 1'b0;
            tok_cnt_a_in = tok_in_cnt_a;
            tok_cnt_b_in = tok_in_cnt_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_a_ff  <= ST_IDLE;
         status_b_ff  <= ST_IDLE;
         tok_valid_ff <= 1'b0;
         tok_phase_ff <= 1'b0;
      end else begin
         status_a_ff  <= status_a_in;
         status_b_ff  <= status_b_in;
         tok_valid_ff <= tok_valid_in;
         tok_phase_ff <= tok_phase_in;
      end
      tok_cnt_a_ff <= tok_cnt_a_in;
      tok_cnt_b_ff <= tok_cnt_b_in;
   end

endmodule

/* hdl/two_group_capacity_arbiter.sv */
`timescale 1ns / 1ps

// Arbiter for two groups of PER_GROUP members sharing one resource. Each request
// transaction is one member asking to enter or leaving; the arbiter then walks
// a grant token through a row of cells, one per member index, checking group A
// and then group B in each cell, and returns one response transaction per grant
// in index order (or a single no-grant response), the final one with tlast set.
// From acceptance until its final response is loaded, the token of a request
// walks through every cell, and a stalled response side holds it back. The
// next request is accepted once the final response is loaded, even while it
// still waits to be taken.

module two_group_capacity_arbiter
   import tgca_pkg::*;
#(
   parameter int PER_GROUP = 5
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [2:0] member, [7:3] zero
   input  logic [1:0] req_tuser,   // [0] command, [1] group

   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] grant_member, [7:3] zero
   output logic [1:0] rsp_tuser,   // [0] grant_valid, [1] grant_group
   output logic       rsp_tlast,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);

   localparam int CW = $clog2(PER_GROUP + 1);

   state_type state_ff, state_in;

   logic [MAX_W-1:0]    max_ff;
   logic [CW-1:0]       cnt_a_ff, cnt_a_in;
   logic [CW-1:0]       cnt_b_ff, cnt_b_in;

   logic                pend_valid_ff, pend_valid_in;
   logic                pend_grp_ff, pend_grp_in;
   logic [MEMBER_W-1:0] pend_member_ff, pend_member_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_grant_ff, rsp_grant_in;
   logic                rsp_grp_ff, rsp_grp_in;
   logic [MEMBER_W-1:0] rsp_member_ff, rsp_member_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                tv [PER_GROUP+1];
   logic [CW-1:0]       ca [PER_GROUP+1];
   logic [CW-1:0]       cb [PER_GROUP+1];
   cell_grant_type      cell_grant [PER_GROUP];
   logic [PER_GROUP-1:0] cell_drop;

   wr_type              wr;
   logic                req_fire;
   logic                step;
   logic                stall;
   logic                out_free;
   logic                any_grant;
   logic                grant_grp;
   logic [MEMBER_W-1:0] grant_member;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign wr.en      = req_fire;
   assign wr.leave   = req_tuser[0];
   assign wr.grp     = req_tuser[1];

   assign tv[0] = (state_ff == S_START);
   assign ca[0] = cnt_a_ff;
   assign cb[0] = cnt_b_ff;

   for (genvar i = 0; i < PER_GROUP; i++) begin : g_cell
      tgca_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .step          (step),
         .wr            (wr),
         .wr_member     (req_tdata[MEMBER_W-1:0]),
         .max_inside    (max_ff),
         .tok_in_valid  (tv[i]),
         .tok_in_cnt_a  (ca[i]),
         .tok_in_cnt_b  (cb[i]),
         .tok_out_valid (tv[i+1]),
         .tok_out_cnt_a (ca[i+1]),
         .tok_out_cnt_b (cb[i+1]),
         .grant         (cell_grant[i]),
         .drop          (cell_drop[i])
      );
   end

   always_comb begin
      any_grant    = 1'b0;
      grant_grp    = 1'b0;
      grant_member = '0;
      for (int i = 0; i < PER_GROUP; i++) begin
         if (cell_grant[i].valid) begin
            any_grant    = 1'b1;
            grant_grp    = grant_grp | cell_grant[i].grp;
            grant_member = grant_member | MEMBER_W'(i);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign stall    = any_grant && pend_valid_ff && !out_free;
   assign step     = (state_ff == S_START) || ((state_ff == S_SCAN) && !stall);

   always_comb begin
      state_in       = state_ff;
      cnt_a_in       = cnt_a_ff;
      cnt_b_in       = cnt_b_ff;
      pend_valid_in  = pend_valid_ff;
      pend_grp_in    = pend_grp_ff;
      pend_member_in = pend_member_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_grant_in   = rsp_grant_ff;
      rsp_grp_in     = rsp_grp_ff;
      rsp_member_in  = rsp_member_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (|cell_drop) begin
                  if (wr.grp) begin
                     cnt_b_in = cnt_b_ff - CW'(1);
                  end else begin
                     cnt_a_in = cnt_a_ff - CW'(1);
                  end
               end
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (step) begin
               if (any_grant) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_grant_in  = 1'b1;
                     rsp_grp_in    = pend_grp_ff;
                     rsp_member_in = pend_member_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_grp_in    = grant_grp;
                  pend_member_in = grant_member;
               end
               if (tv[PER_GROUP]) begin
                  cnt_a_in = ca[PER_GROUP];
                  cnt_b_in = cb[PER_GROUP];
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_grant_in  = pend_valid_ff;
               rsp_grp_in    = pend_valid_ff && pend_grp_ff;
               rsp_member_in = pend_valid_ff ? pend_member_ff : '0;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_ff        <= MAX_W'(1);
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_data;
         end
      end
      pend_grp_ff    <= pend_grp_in;
      pend_member_ff <= pend_member_in;
      rsp_grant_ff   <= rsp_grant_in;
      rsp_grp_ff     <= rsp_grp_in;
      rsp_member_ff  <= rsp_member_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8 - MEMBER_W){1'b0}}, rsp_member_ff};
   assign rsp_tuser  = {rsp_grp_ff, rsp_grant_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
